// File: src/mlcf_pkg.sv
// shared types, constants and the crc helper for the frame deframer
package mlcf_pkg;

  // header magic and crc polynomial
  localparam logic [7:0]  MAGIC_FIRST  = 8'hAA;
  localparam logic [7:0]  MAGIC_SECOND = 8'h55;
  localparam logic [15:0] CRC_POLY     = 16'h1021;

  // header byte positions
  localparam logic [2:0] HDR_IDX_MAGIC0 = 3'd0;
  localparam logic [2:0] HDR_IDX_MAGIC1 = 3'd1;
  localparam logic [2:0] HDR_IDX_LAST   = 3'd7;

  // register widths and reset value
  localparam int unsigned MAX_LEN_BITS  = 24;
  localparam logic [MAX_LEN_BITS-1:0] MAX_LEN_RESET = 24'd204800;
  localparam int unsigned HDR_LEN_BITS  = 32;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QUEUE_PTR_W   = 1;
  localparam int unsigned QUEUE_CNT_W   = 2;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD    = 2'd0,
    KIND_BAD_MAGIC  = 2'd1,
    KIND_BAD_LENGTH = 2'd2
  } kind_t;

  // one queued operation for the back end
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        last;
    logic [15:0] exp_crc;
  } op_t;

  // crc-16/xmodem over one byte, msb first
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// File: src/mlcf_in_if.sv
// received byte channel
interface mlcf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: src/mlcf_out_if.sv
// deframer result channel
interface mlcf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] payload_byte;
  logic       frame_end;
  logic       crc_match;

  modport source (output valid, output out_kind, output payload_byte,
                  output frame_end, output crc_match, input ready);
  modport sink   (input valid, input out_kind, input payload_byte,
                  input frame_end, input crc_match, output ready);
endinterface

// File: src/magic_length_crc_frame_deframer.sv
// Length-prefixed frame deframer with CRC-16/XMODEM check. Takes one received
// byte per cycle, sustained: a byte is accepted in every cycle while the
// two-entry queue between the header parser and the CRC/output stage has room,
// so the only stall comes from the result side. A result is registered: the
// byte enters the queue at the accepting edge and moves into the output
// register when that register is free. Header bytes 0 to 6 give no result;
// the eighth gives a bad-magic or bad-length status or opens the payload.
// Every payload byte is passed out, and the last one carries frame_end and
// crc_match; frames with crc_match low are to be discarded downstream.
// max_frame_length may be written only while the block is idle.
module magic_length_crc_frame_deframer #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  mlcf_in_if.sink                            rx,
  mlcf_out_if.source                         result,
  input  logic                               cfg_we,
  input  logic [mlcf_pkg::MAX_LEN_BITS-1:0]  cfg_data
);

  logic                              push;
  mlcf_pkg::op_t                     push_op;
  logic                              q_ready;
  logic                              pop;
  logic                              head_valid;
  mlcf_pkg::op_t                     head_op;
  logic [mlcf_pkg::QUEUE_CNT_W-1:0]  q_count;

  // header parsing and byte counting
  mlcf_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_ready  (q_ready),
    .push     (push),
    .push_op  (push_op)
  );

  // decoupling queue
  mlcf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .ready      (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op),
    .count      (q_count)
  );

  // crc and result register
  mlcf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .result     (result)
  );

`ifndef NO_ASSERTIONS
  // the front never pushes into a full queue
  assert property (@(posedge clk) disable iff (rst)
    push |-> q_ready)
    else $error("push into full queue");

  // fill count stays within the queue depth
  assert property (@(posedge clk) disable iff (rst)
    q_count <= mlcf_pkg::QUEUE_CNT_W'(mlcf_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

  // frame end only on payload items
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.frame_end) |->
      (result.out_kind == mlcf_pkg::KIND_PAYLOAD))
    else $error("frame end on status item");

  // crc match only with frame end
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.crc_match) |-> result.frame_end)
    else $error("crc match without frame end");
`endif

endmodule

// File: src/mlcf_front.sv
// front end: header parsing, length checks and payload byte counting
module mlcf_front #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  mlcf_in_if.sink                              rx,
  input  logic                                 cfg_we,
  input  logic [mlcf_pkg::MAX_LEN_BITS-1:0]    cfg_data,
  input  logic                                 q_ready,
  output logic                                 push,
  output mlcf_pkg::op_t                        push_op
);

  logic                               max_frame_length;
  logic [mlcf_pkg::MAX_LEN_BITS-1:0]  max_len;
  logic                               in_payload, in_payload_next;
  logic [2:0]                         header_index, header_index_next;
  logic                               magic_ok, magic_ok_next;
  logic [47:0]                        header_fields, header_fields_next;
  logic [LENGTH_BITS-1:0]             bytes_remaining, bytes_remaining_next;
  logic [15:0]                        expected_crc, expected_crc_next;
  logic [mlcf_pkg::HDR_LEN_BITS-1:0]  hdr_len;
  logic                               len_bad;
  logic                               accept;

  assign max_frame_length = cfg_we;
  assign rx.ready = q_ready;
  assign accept   = rx.valid && q_ready;

  // length taken from the completed header
  assign hdr_len = header_fields_next[47:16];
  assign len_bad = (hdr_len == '0)
                || (hdr_len > {{(mlcf_pkg::HDR_LEN_BITS-mlcf_pkg::MAX_LEN_BITS){1'b0}}, max_len})
                || ((hdr_len >> LENGTH_BITS) != '0);

  // next-state and queue push
  always_comb begin
    in_payload_next      = in_payload;
    header_index_next    = header_index;
    magic_ok_next        = magic_ok;
    header_fields_next   = header_fields;
    bytes_remaining_next = bytes_remaining;
    expected_crc_next    = expected_crc;
    push                 = 1'b0;
    push_op.kind         = mlcf_pkg::KIND_PAYLOAD;
    push_op.data         = rx.rx_byte;
    push_op.last         = 1'b0;
    push_op.exp_crc      = expected_crc;
    if (!in_payload) begin
      if (header_index == mlcf_pkg::HDR_IDX_MAGIC0) begin
        magic_ok_next = (rx.rx_byte == mlcf_pkg::MAGIC_FIRST);
      end else if (header_index == mlcf_pkg::HDR_IDX_MAGIC1) begin
        magic_ok_next = magic_ok && (rx.rx_byte == mlcf_pkg::MAGIC_SECOND);
      end else begin
        header_fields_next = {header_fields[39:0], rx.rx_byte};
      end
    end
    if (accept) begin
      if (in_payload) begin
        // payload byte, count down to the frame end
        push                 = 1'b1;
        bytes_remaining_next = bytes_remaining - 1'b1;
        push_op.last         = (bytes_remaining == LENGTH_BITS'(1));
        if (bytes_remaining == LENGTH_BITS'(1)) begin
          in_payload_next = 1'b0;
        end
      end else begin
        header_index_next = header_index + 3'd1;
        if (header_index == mlcf_pkg::HDR_IDX_LAST) begin
          // header verdict, magic wins over length
          push_op.data = 8'h00;
          if (!magic_ok) begin
            push         = 1'b1;
            push_op.kind = mlcf_pkg::KIND_BAD_MAGIC;
          end else if (len_bad) begin
            push         = 1'b1;
            push_op.kind = mlcf_pkg::KIND_BAD_LENGTH;
          end else begin
            bytes_remaining_next = hdr_len[LENGTH_BITS-1:0];
            expected_crc_next    = header_fields_next[15:0];
            in_payload_next      = 1'b1;
          end
        end
      end
    end else begin
      magic_ok_next      = magic_ok;
      header_fields_next = header_fields;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload   <= 1'b0;
      header_index <= '0;
      magic_ok     <= 1'b0;
      max_len      <= mlcf_pkg::MAX_LEN_RESET;
    end else begin
      in_payload   <= in_payload_next;
      header_index <= header_index_next;
      magic_ok     <= magic_ok_next;
      if (max_frame_length) begin
        max_len <= cfg_data;
      end
    end
  end

  // header and frame data
  always_ff @(posedge clk) begin
    header_fields   <= header_fields_next;
    bytes_remaining <= bytes_remaining_next;
    expected_crc    <= expected_crc_next;
  end

endmodule

// File: src/mlcf_queue.sv
// two-entry queue between front and back
module mlcf_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  mlcf_pkg::op_t                       push_op,
  output logic                                ready,
  input  logic                                pop,
  output logic                                head_valid,
  output mlcf_pkg::op_t                       head_op,
  output logic [mlcf_pkg::QUEUE_CNT_W-1:0]    count
);

  mlcf_pkg::op_t                        mem [mlcf_pkg::QUEUE_DEPTH];
  logic [mlcf_pkg::QUEUE_PTR_W-1:0]     wr_ptr;
  logic [mlcf_pkg::QUEUE_PTR_W-1:0]     rd_ptr;

  function automatic logic [mlcf_pkg::QUEUE_CNT_W-1:0] QUEUE_CNT_W_ONE(logic b);
    return {{(mlcf_pkg::QUEUE_CNT_W-1){1'b0}}, b};
  endfunction

  assign ready      = (count != mlcf_pkg::QUEUE_CNT_W'(mlcf_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QUEUE_CNT_W_ONE(push) - QUEUE_CNT_W_ONE(pop);
    end
  end

endmodule

// File: src/mlcf_back.sv
// back end: running crc and the registered result stage
module mlcf_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  mlcf_pkg::op_t   head_op,
  output logic            pop,
  mlcf_out_if.source      result
);

  logic            out_valid;
  mlcf_pkg::kind_t out_kind;
  logic [7:0]      out_byte;
  logic            out_end;
  logic            out_match;
  logic [15:0]     running_crc;
  logic [15:0]     crc_new;

  assign pop     = head_valid && (!out_valid || result.ready);
  assign crc_new = mlcf_pkg::crc16_byte(running_crc, head_op.data);

  // result channel
  assign result.valid        = out_valid;
  assign result.out_kind     = out_kind;
  assign result.payload_byte = out_byte;
  assign result.frame_end    = out_end;
  assign result.crc_match    = out_match;

  // output valid and running crc
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      running_crc <= '0;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (pop && head_op.kind == mlcf_pkg::KIND_PAYLOAD) begin
        running_crc <= head_op.last ? 16'h0000 : crc_new;
      end
    end
  end

  // output item
  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind  <= head_op.kind;
      out_byte  <= head_op.data;
      out_end   <= head_op.last;
      out_match <= head_op.last && (crc_new == head_op.exp_crc);
    end
  end

endmodule

// File: verif/tb_magic_length_crc_frame_deframer.sv
// self-checking testbench for the length-prefixed crc frame deframer
module tb_magic_length_crc_frame_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEN_BITS = 24;

  // tracks deframer state per accepted byte and holds the results it owes
  class frame_result_tracker;
    typedef struct packed {
      mlcf_pkg::kind_t kind;
      logic [7:0]      data;
      logic            last;
      logic            match;
    } frame_result_t;

    frame_result_t expected_results[$];
    bit [23:0] max_len;
    bit [32:0] len_fit;
    bit        in_payload;
    bit [2:0]  hdr_idx;
    bit        magic_ok;
    bit [47:0] hdr_fields;
    bit [31:0] remaining;
    bit [15:0] hdr_crc;
    bit [15:0] run_crc;
    int n_in, n_out, n_errors;
    int n_crc_ok, n_crc_bad, n_bad_magic, n_bad_length;

    function new(int unsigned len_bits);
      len_fit = (33'd1 << len_bits) - 33'd1;
      max_len = mlcf_pkg::MAX_LEN_RESET;
    endfunction

    // crc-16/xmodem, one input bit at a time
    static function bit [15:0] crc_step(bit [15:0] c, bit [7:0] b);
      bit fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c = {c[14:0], 1'b0} ^ (fb ? mlcf_pkg::CRC_POLY : 16'h0000);
      end
      return c;
    endfunction

    function void note_rx_byte(bit [7:0] b);
      frame_result_t r;
      bit [31:0] len;
      n_in++;
      // payload bytes pass straight through
      if (in_payload) begin
        run_crc = crc_step(run_crc, b);
        remaining = remaining - 32'd1;
        r.kind = mlcf_pkg::KIND_PAYLOAD;
        r.data = b;
        r.last = (remaining == 0);
        r.match = r.last && (run_crc == hdr_crc);
        expected_results.push_back(r);
        if (r.last) in_payload = 1'b0;
        return;
      end
      // header collection
      if (hdr_idx == mlcf_pkg::HDR_IDX_MAGIC0) magic_ok = (b == mlcf_pkg::MAGIC_FIRST);
      else if (hdr_idx == mlcf_pkg::HDR_IDX_MAGIC1)
        magic_ok = magic_ok && (b == mlcf_pkg::MAGIC_SECOND);
      else hdr_fields = {hdr_fields[39:0], b};
      hdr_idx = hdr_idx + 3'd1;
      if (hdr_idx != 3'd0) return;
      // verdict on the eighth byte
      len = hdr_fields[47:16];
      r.data = 8'h00;
      r.last = 1'b0;
      r.match = 1'b0;
      if (!magic_ok) begin
        r.kind = mlcf_pkg::KIND_BAD_MAGIC;
        expected_results.push_back(r);
      end else if (len == 0 || len > {8'h00, max_len} || {1'b0, len} > len_fit) begin
        r.kind = mlcf_pkg::KIND_BAD_LENGTH;
        expected_results.push_back(r);
      end else begin
        remaining = len;
        hdr_crc = hdr_fields[15:0];
        run_crc = 16'h0000;
        in_payload = 1'b1;
      end
    endfunction

    task report_mismatch(string msg);
      n_errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic [1:0] kind, logic [7:0] data, logic last, logic match);
      frame_result_t want;
      n_out++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d byte %02h end %0b match %0b",
                                  kind, data, last, match));
        return;
      end
      want = expected_results.pop_front();
      if (kind !== want.kind || data !== want.data || last !== want.last ||
          match !== want.match) begin
        report_mismatch($sformatf("got kind %0d byte %02h end %0b match %0b, want %0d %02h %0b %0b",
                                  kind, data, last, match, want.kind, want.data,
                                  want.last, want.match));
        return;
      end
      // tally what was covered
      if (want.kind == mlcf_pkg::KIND_BAD_MAGIC) n_bad_magic++;
      else if (want.kind == mlcf_pkg::KIND_BAD_LENGTH) n_bad_length++;
      else if (want.last && want.match) n_crc_ok++;
      else if (want.last) n_crc_bad++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [mlcf_pkg::MAX_LEN_BITS-1:0] cfg_data;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int unsigned mid_max;

  mlcf_in_if rxi();
  mlcf_out_if res();

  frame_result_tracker sb = new(LEN_BITS);

  magic_length_crc_frame_deframer #(.LENGTH_BITS(LEN_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .rx       (rxi),
    .result   (res),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (!rst && res.valid && res.ready)
      sb.check_result(res.out_kind, res.payload_byte, res.frame_end, res.crc_match);
  end

  // result side: random stalls plus one long hold-off
  initial begin : result_side
    int n;
    wait (rst == 1'b0);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res.ready <= 1'b0;
        repeat (100) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 10);
        res.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      res.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // offer one byte, return at the edge where it is taken
  task automatic send_byte(logic [7:0] b);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      rxi.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rxi.valid <= 1'b1;
    rxi.rx_byte <= b;
    do @(posedge clk); while (!rxi.ready);
    sb.note_rx_byte(b);
  endtask

  task automatic send_header(logic [7:0] b0, logic [7:0] b1, logic [31:0] len,
                             logic [15:0] crc);
    send_byte(b0);
    send_byte(b1);
    for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
  endtask

  // well-formed frame with random payload, crc optionally corrupted
  task automatic send_frame(int unsigned len, bit corrupt);
    logic [7:0] payload[$];
    logic [15:0] crc;
    crc = 16'h0000;
    for (int i = 0; i < len; i++) begin
      payload.push_back(8'($urandom_range(0, 255)));
      crc = frame_result_tracker::crc_step(crc, payload[i]);
    end
    if (corrupt) crc ^= 16'($urandom_range(1, 16'hFFFF));
    send_header(mlcf_pkg::MAGIC_FIRST, mlcf_pkg::MAGIC_SECOND, len, crc);
    foreach (payload[i]) send_byte(payload[i]);
  endtask

  // mostly good frames, with garbage and rejected headers mixed in
  task automatic send_random_frame();
    int unsigned pick, lim;
    logic [31:0] m, len;
    logic [7:0] b0, b1;
    m = {8'h00, sb.max_len};
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      b0 = 8'($urandom_range(0, 255));
      if (b0 == mlcf_pkg::MAGIC_FIRST) b0 = ~b0;
      send_header(b0, 8'($urandom_range(0, 255)), $urandom, 16'($urandom));
    end else if (pick < 18) begin
      b1 = 8'($urandom_range(0, 255));
      if (b1 == mlcf_pkg::MAGIC_SECOND) b1 = ~b1;
      send_header(mlcf_pkg::MAGIC_FIRST, b1, $urandom, 16'($urandom));
    end else if (pick < 32 || m == 0) begin
      case ($urandom_range(0, 2))
        0: len = 32'd0;
        1: len = m + 32'd1;
        default: len = {8'($urandom_range(1, 255)), 24'($urandom)};
      endcase
      send_header(mlcf_pkg::MAGIC_FIRST, mlcf_pkg::MAGIC_SECOND, len, 16'($urandom));
    end else begin
      lim = (m < 16) ? m : 16;
      if ($urandom_range(0, 19) == 0) lim = (m < 120) ? m : 120;
      send_frame($urandom_range(1, lim), $urandom_range(0, 6) == 0);
    end
  endtask

  task automatic run_random(int budget);
    int start;
    start = sb.n_in;
    while (sb.n_in - start < budget) send_random_frame();
  endtask

  // stop offering, wait for every owed result and let the pipeline drain
  task automatic settle();
    rxi.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_max_len(logic [mlcf_pkg::MAX_LEN_BITS-1:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.max_len = v;
  endtask

  // main stimulus
  initial begin : stimulus
    logic [15:0] crc;
    rxi.valid = 1'b0;
    rxi.rx_byte = 8'h00;
    res.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: one-byte frame, bad magic over zero length, zero length
    crc = frame_result_tracker::crc_step(16'h0000, 8'hFF);
    send_header(mlcf_pkg::MAGIC_FIRST, mlcf_pkg::MAGIC_SECOND, 32'd1, crc);
    send_byte(8'hFF);
    send_header(mlcf_pkg::MAGIC_SECOND, mlcf_pkg::MAGIC_FIRST, 32'd0, 16'h0000);
    send_header(mlcf_pkg::MAGIC_FIRST, mlcf_pkg::MAGIC_SECOND, 32'd0, 16'h1234);

    // reset limit, long frame while the result side holds off
    hold_req = 1'b1;
    send_frame(96, 1'b0);
    run_random(110);

    // smallest nonzero limit, then zero rejects everything
    write_max_len(24'd1);
    run_random(80);
    write_max_len(24'd0);
    run_random(50);

    // widest limit: only zero lengths and lengths beyond the counter width get rejected
    write_max_len(24'hFFFFFF);
    run_random(90);

    mid_max = $urandom_range(3, 40);
    write_max_len(24'(mid_max));
    run_random(90);

    // back to the reset value with no idling on either side
    write_max_len(mlcf_pkg::MAX_LEN_RESET);
    calm = 1'b1;
    run_random(90);
    settle();

    $display("covered %0d bytes in, %0d results: %0d frames crc ok, %0d crc mismatch,",
             sb.n_in, sb.n_out, sb.n_crc_ok, sb.n_crc_bad);
    $display("  %0d bad magic, %0d bad length; limits 204800, 1, 0, 16777215, %0d",
             sb.n_bad_magic, sb.n_bad_length, mid_max);
    if (sb.n_errors == 0 && sb.expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #400000;
    $display("timeout with %0d results still owed", sb.expected_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
